/* hw/rtl/mftt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mftt_pkg
// Shared constants and pipeline item types of the motor feedback turn tracker.
// ----------------------------------------------------------------------------
package mftt_pkg;

    // encoder geometry and round counter
    localparam int COUNTS_PER_TURN = 8192;
    localparam int ROUND_BITS      = 16;
    localparam int RAW_W           = 13;
    localparam int DELTA_W         = RAW_W + 1;
    localparam logic signed [DELTA_W-1:0] HALF_TURN = DELTA_W'(COUNTS_PER_TURN / 2);

    // field widths
    localparam int OFFSET_W  = 14;
    localparam int SCALE_W   = 32;
    localparam int TOTAL_W   = 30;
    localparam int ANGLE_W   = 40;
    localparam int OMEGA_W   = 32;
    localparam int SPEED_W   = 16;
    localparam int CURRENT_W = 16;
    localparam int TEMP_W    = 8;

    // product widths and rounding shifts
    localparam int ANGLE_PROD_W = TOTAL_W + SCALE_W + 1;
    localparam int OMEGA_PROD_W = SPEED_W + SCALE_W + 1;
    localparam int ANGLE_SHIFT  = 16;
    localparam int OMEGA_SHIFT  = 8;

    // configuration register map
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MECH_OFFSET = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ANGLE_SCALE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OMEGA_SCALE = 2'd2;

    localparam logic [SCALE_W-1:0] ANGLE_SCALE_RESET = 32'd3294198;
    localparam logic [SCALE_W-1:0] OMEGA_SCALE_RESET = 32'd1756894;

    // request kinds
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // request after unwrap, before scaling
    typedef struct packed {
        logic                        item_kind;
        logic signed [TOTAL_W-1:0]   total_count;
        logic signed [SPEED_W-1:0]   speed_rpm;
        logic signed [CURRENT_W-1:0] current_out;
        logic [TEMP_W-1:0]           temperature_out;
        logic                        online;
    } mftt_unwrap_t;

    // request after the multipliers
    typedef struct packed {
        logic                           item_kind;
        logic signed [TOTAL_W-1:0]      total_count;
        logic signed [ANGLE_PROD_W-1:0] angle_prod;
        logic signed [OMEGA_PROD_W-1:0] omega_prod;
        logic signed [CURRENT_W-1:0]    current_out;
        logic [TEMP_W-1:0]              temperature_out;
        logic                           online;
    } mftt_prod_t;

endpackage

/* hw/rtl/mftt_unwrap.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mftt_unwrap
// Wrap detection, round counter, liveness state and multi-turn count.
// ----------------------------------------------------------------------------
module mftt_unwrap
    import mftt_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_opcode,
    input  logic [RAW_W-1:0]            s_encoder_raw,
    input  logic signed [SPEED_W-1:0]   s_speed_rpm,
    input  logic signed [CURRENT_W-1:0] s_current_raw,
    input  logic [TEMP_W-1:0]           s_temperature_raw,
    input  logic signed [OFFSET_W-1:0]  mech_offset,
    output logic                        out_valid,
    input  logic                        out_ready,
    output mftt_unwrap_t                out_item
);

    logic                        valid_reg;
    mftt_unwrap_t                item_reg;
    mftt_unwrap_t                item_next;
    logic [RAW_W-1:0]            prev_count_reg, prev_count_next;
    logic [ROUND_BITS-1:0]       round_count_reg, round_count_next;
    logic                        frame_seen_reg, frame_seen_next;
    logic                        online_reg, online_next;
    logic signed [CURRENT_W-1:0] last_current_reg, last_current_next;
    logic [TEMP_W-1:0]           last_temp_reg, last_temp_next;
    logic signed [DELTA_W-1:0]   delta;
    logic signed [63:0]          sum;
    logic                        accept;

    assign s_ready   = !valid_reg || out_ready;
    assign accept    = s_valid && s_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // next state and the unwrapped request
    always_comb begin
        prev_count_next   = prev_count_reg;
        round_count_next  = round_count_reg;
        frame_seen_next   = frame_seen_reg;
        online_next       = online_reg;
        last_current_next = last_current_reg;
        last_temp_next    = last_temp_reg;

        delta = $signed({1'b0, s_encoder_raw}) - $signed({1'b0, prev_count_reg});

        if (s_opcode == OP_FRAME) begin
            if (delta < -HALF_TURN) begin
                round_count_next = round_count_reg + 1'b1;
            end else if (delta > HALF_TURN) begin
                round_count_next = round_count_reg - 1'b1;
            end
            prev_count_next   = s_encoder_raw;
            last_current_next = s_current_raw;
            last_temp_next    = s_temperature_raw;
            frame_seen_next   = 1'b1;
        end else begin
            online_next     = frame_seen_reg;
            frame_seen_next = 1'b0;
        end

        sum = 64'(signed'(round_count_next)) * 64'(COUNTS_PER_TURN)
              + 64'($signed({1'b0, s_encoder_raw}))
              + 64'(mech_offset);

        item_next.item_kind       = s_opcode;
        item_next.total_count     = (s_opcode == OP_FRAME) ? sum[TOTAL_W-1:0] : '0;
        item_next.speed_rpm       = (s_opcode == OP_FRAME) ? s_speed_rpm : '0;
        item_next.current_out     = last_current_next;
        item_next.temperature_out = last_temp_next;
        item_next.online          = online_next;
    end

    // tracking state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_count_reg   <= '0;
            round_count_reg  <= '0;
            frame_seen_reg   <= 1'b0;
            online_reg       <= 1'b0;
            last_current_reg <= '0;
            last_temp_reg    <= '0;
        end else if (accept) begin
            prev_count_reg   <= prev_count_next;
            round_count_reg  <= round_count_next;
            frame_seen_reg   <= frame_seen_next;
            online_reg       <= online_next;
            last_current_reg <= last_current_next;
            last_temp_reg    <= last_temp_next;
        end
    end

    // stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_next;
        end
    end

endmodule

/* hw/rtl/mftt_scale.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mftt_scale
// Angle and speed scaling: multiply stage, then rounding and saturation.
// ----------------------------------------------------------------------------
module mftt_scale
    import mftt_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  mftt_unwrap_t                in_item,
    input  logic [SCALE_W-1:0]          angle_scale,
    input  logic [SCALE_W-1:0]          omega_scale,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_item_kind,
    output logic signed [TOTAL_W-1:0]   m_total_count,
    output logic signed [ANGLE_W-1:0]   m_angle_rad,
    output logic signed [OMEGA_W-1:0]   m_omega_rad,
    output logic signed [CURRENT_W-1:0] m_current_out,
    output logic [TEMP_W-1:0]           m_temperature_out,
    output logic                        m_online
);

    logic                           prod_valid_reg;
    mftt_prod_t                     prod_reg;
    mftt_prod_t                     prod_next;
    logic                           out_valid_reg;
    logic                           out_ready;
    logic signed [ANGLE_PROD_W-1:0] angle_sh;
    logic signed [OMEGA_PROD_W-1:0] omega_sh;
    logic [ANGLE_PROD_W-ANGLE_W:0]  angle_hi;
    logic [OMEGA_PROD_W-OMEGA_W:0]  omega_hi;
    logic signed [ANGLE_W-1:0]      angle_next;
    logic signed [OMEGA_W-1:0]      omega_next;

    assign out_ready = !out_valid_reg || m_ready;
    assign in_ready  = !prod_valid_reg || out_ready;
    assign m_valid   = out_valid_reg;

    // multipliers
    always_comb begin
        prod_next.item_kind       = in_item.item_kind;
        prod_next.total_count     = in_item.total_count;
        prod_next.angle_prod      = ANGLE_PROD_W'(in_item.total_count)
                                    * ANGLE_PROD_W'($signed({1'b0, angle_scale}));
        prod_next.omega_prod      = OMEGA_PROD_W'(in_item.speed_rpm)
                                    * OMEGA_PROD_W'($signed({1'b0, omega_scale}));
        prod_next.current_out     = in_item.current_out;
        prod_next.temperature_out = in_item.temperature_out;
        prod_next.online          = in_item.online;
    end

    // round half up, then saturate
    always_comb begin
        angle_sh = (prod_reg.angle_prod + (ANGLE_PROD_W'(1) <<< (ANGLE_SHIFT - 1)))
                   >>> ANGLE_SHIFT;
        omega_sh = (prod_reg.omega_prod + (OMEGA_PROD_W'(1) <<< (OMEGA_SHIFT - 1)))
                   >>> OMEGA_SHIFT;
        angle_hi = angle_sh[ANGLE_PROD_W-1:ANGLE_W-1];
        omega_hi = omega_sh[OMEGA_PROD_W-1:OMEGA_W-1];

        if ((&angle_hi) || !(|angle_hi)) begin
            angle_next = angle_sh[ANGLE_W-1:0];
        end else if (angle_sh[ANGLE_PROD_W-1]) begin
            angle_next = {1'b1, {(ANGLE_W-1){1'b0}}};
        end else begin
            angle_next = {1'b0, {(ANGLE_W-1){1'b1}}};
        end

        if ((&omega_hi) || !(|omega_hi)) begin
            omega_next = omega_sh[OMEGA_W-1:0];
        end else if (omega_sh[OMEGA_PROD_W-1]) begin
            omega_next = {1'b1, {(OMEGA_W-1){1'b0}}};
        end else begin
            omega_next = {1'b0, {(OMEGA_W-1){1'b1}}};
        end
    end

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (in_ready) begin
                prod_valid_reg <= in_valid;
            end
            if (out_ready) begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    // product register
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            prod_reg <= prod_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (prod_valid_reg && out_ready) begin
            m_item_kind       <= prod_reg.item_kind;
            m_total_count     <= prod_reg.total_count;
            m_angle_rad       <= angle_next;
            m_omega_rad       <= omega_next;
            m_current_out     <= prod_reg.current_out;
            m_temperature_out <= prod_reg.temperature_out;
            m_online          <= prod_reg.online;
        end
    end

endmodule

/* hw/rtl/motor_feedback_turn_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_feedback_turn_tracker
// Multi-turn unwrap of motor feedback frames with angle, speed and liveness.
// ----------------------------------------------------------------------------
// Requests enter on the s_ channel (valid/ready): opcode 0 carries a feedback
// frame, opcode 1 a liveness tick. Each request yields exactly one result on
// the m_ channel, in order. A frame steps the round counter when the encoder
// count jumps by more than half a turn and reports total count, angle
// (Q.16 rad) and speed (Q16.16 rad/s); a tick reports zeros there and sets
// online when a frame came since the previous tick, else clears it.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata): index 0
// mechanical offset, 1 angle scale, 2 speed scale; other indexes are ignored.
// A result passes the unwrap register, product register and rounded result
// register; one request per cycle is sustained while m_ready stays high, and
// the two multipliers (63- and 49-bit products) sit in their own stage.
// Reset (aresetn low, synchronous) clears the round counter, previous count,
// liveness state and stored current and temperature, and loads the default
// scales. When the receiver stalls, the three stages fill and then s_ready
// drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module motor_feedback_turn_tracker
    import mftt_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [CFG_INDEX_W-1:0]      cfg_index,
    input  logic [SCALE_W-1:0]          cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_opcode,
    input  logic [RAW_W-1:0]            s_encoder_raw,
    input  logic signed [SPEED_W-1:0]   s_speed_rpm,
    input  logic signed [CURRENT_W-1:0] s_current_raw,
    input  logic [TEMP_W-1:0]           s_temperature_raw,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_item_kind,
    output logic signed [TOTAL_W-1:0]   m_total_count,
    output logic signed [ANGLE_W-1:0]   m_angle_rad,
    output logic signed [OMEGA_W-1:0]   m_omega_rad,
    output logic signed [CURRENT_W-1:0] m_current_out,
    output logic [TEMP_W-1:0]           m_temperature_out,
    output logic                        m_online
);

    logic signed [OFFSET_W-1:0] mech_offset_reg;
    logic [SCALE_W-1:0]         angle_scale_reg;
    logic [SCALE_W-1:0]         omega_scale_reg;
    logic                       unwrap_valid;
    logic                       unwrap_ready;
    mftt_unwrap_t               unwrap_item;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mech_offset_reg <= '0;
            angle_scale_reg <= ANGLE_SCALE_RESET;
            omega_scale_reg <= OMEGA_SCALE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MECH_OFFSET: mech_offset_reg <= cfg_wdata[OFFSET_W-1:0];
                CFG_ANGLE_SCALE: angle_scale_reg <= cfg_wdata;
                CFG_OMEGA_SCALE: omega_scale_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // unwrap and liveness stage
    mftt_unwrap u_unwrap (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_encoder_raw     (s_encoder_raw),
        .s_speed_rpm       (s_speed_rpm),
        .s_current_raw     (s_current_raw),
        .s_temperature_raw (s_temperature_raw),
        .mech_offset       (mech_offset_reg),
        .out_valid         (unwrap_valid),
        .out_ready         (unwrap_ready),
        .out_item          (unwrap_item)
    );

    // scaling stages and result register
    mftt_scale u_scale (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_valid          (unwrap_valid),
        .in_ready          (unwrap_ready),
        .in_item           (unwrap_item),
        .angle_scale       (angle_scale_reg),
        .omega_scale       (omega_scale_reg),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_item_kind       (m_item_kind),
        .m_total_count     (m_total_count),
        .m_angle_rad       (m_angle_rad),
        .m_omega_rad       (m_omega_rad),
        .m_current_out     (m_current_out),
        .m_temperature_out (m_temperature_out),
        .m_online          (m_online)
    );

endmodule

/* sim/motor_feedback_turn_tracker_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_feedback_turn_tracker_tb
// Self-checking bench for the multi-turn encoder unwrap with angle and speed.
// ----------------------------------------------------------------------------
// A local predictor tracks the round counter, previous count, liveness and
// stored current/temperature, and computes each expected result as a request
// is accepted. A checker compares every accepted result field by field with
// the oldest prediction. Directed cases cover the wrap thresholds, liveness
// and register extremes; random phases walk the shaft with random content
// under several register settings; a fast forward spin steps the round
// counter on every other frame with the angle scale register at full scale.
// ----------------------------------------------------------------------------
module motor_feedback_turn_tracker_tb;
    import mftt_pkg::*;

    localparam int PIPE_LATENCY   = 3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF_LEN   = 200;
    localparam int PHASE_ITEMS    = 120;
    localparam int SPIN_FRAMES    = 100;
    localparam int REPORT_LINES   = 40;

    localparam logic [CFG_INDEX_W-1:0]      CFG_UNUSED = 2'd3;
    localparam logic signed [OFFSET_W-1:0]  OFFSET_MIN = 14'h2000;
    localparam logic signed [OFFSET_W-1:0]  OFFSET_MAX = 14'h1FFF;

    // one predicted result
    typedef struct {
        logic                        kind;
        logic signed [TOTAL_W-1:0]   total;
        logic signed [ANGLE_W-1:0]   angle;
        logic signed [OMEGA_W-1:0]   omega;
        logic signed [CURRENT_W-1:0] current;
        logic [TEMP_W-1:0]           temp;
        logic                        online;
    } reading_t;

    logic                        aclk;
    logic                        aresetn           = 1'b0;
    logic                        cfg_we            = 1'b0;
    logic [CFG_INDEX_W-1:0]      cfg_index         = CFG_MECH_OFFSET;
    logic [SCALE_W-1:0]          cfg_wdata         = '0;
    logic                        s_valid           = 1'b0;
    logic                        s_ready;
    logic                        s_opcode          = OP_FRAME;
    logic [RAW_W-1:0]            s_encoder_raw     = '0;
    logic signed [SPEED_W-1:0]   s_speed_rpm       = '0;
    logic signed [CURRENT_W-1:0] s_current_raw     = '0;
    logic [TEMP_W-1:0]           s_temperature_raw = '0;
    logic                        m_valid;
    logic                        m_ready           = 1'b0;
    logic                        m_item_kind;
    logic signed [TOTAL_W-1:0]   m_total_count;
    logic signed [ANGLE_W-1:0]   m_angle_rad;
    logic signed [OMEGA_W-1:0]   m_omega_rad;
    logic signed [CURRENT_W-1:0] m_current_out;
    logic [TEMP_W-1:0]           m_temperature_out;
    logic                        m_online;

    // predictor state and register copies
    logic [RAW_W-1:0]            last_raw      = '0;
    logic signed [ROUND_BITS-1:0] turns        = '0;
    logic                        fresh_frame   = 1'b0;
    logic                        link_up       = 1'b0;
    logic signed [CURRENT_W-1:0] held_current  = '0;
    logic [TEMP_W-1:0]           held_temp     = '0;
    logic signed [OFFSET_W-1:0]  zero_offset   = '0;
    logic [SCALE_W-1:0]          rad_per_count = ANGLE_SCALE_RESET;
    logic [SCALE_W-1:0]          rad_s_per_rpm = OMEGA_SCALE_RESET;

    reading_t         due_readings[$];
    int               mismatch_count  = 0;
    int               result_no       = 0;
    int               idle_cycles     = 0;
    int               hold_off_cycles = 0;
    bit               idling          = 1'b1;
    logic [RAW_W-1:0] shaft_pos       = '0;

    motor_feedback_turn_tracker u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_encoder_raw     (s_encoder_raw),
        .s_speed_rpm       (s_speed_rpm),
        .s_current_raw     (s_current_raw),
        .s_temperature_raw (s_temperature_raw),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_item_kind       (m_item_kind),
        .m_total_count     (m_total_count),
        .m_angle_rad       (m_angle_rad),
        .m_omega_rad       (m_omega_rad),
        .m_current_out     (m_current_out),
        .m_temperature_out (m_temperature_out),
        .m_online          (m_online)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // clamp to a w-bit signed range
    function automatic longint clamp_signed(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -(longint'(1) <<< (w - 1));
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // unwrap the count, scale angle and speed, update liveness
    function automatic reading_t unwrap_and_scale(
        input logic                        op,
        input logic [RAW_W-1:0]            raw,
        input logic signed [SPEED_W-1:0]   rpm,
        input logic signed [CURRENT_W-1:0] cur,
        input logic [TEMP_W-1:0]           temp
    );
        reading_t                  r;
        int                        jump;
        longint                    sum;
        longint                    total;
        longint                    prod;
        longint                    speed;
        logic signed [TOTAL_W-1:0] total_w;
        r.kind  = op;
        r.total = '0;
        r.angle = '0;
        r.omega = '0;
        if (op == OP_FRAME) begin
            jump = int'(raw) - int'(last_raw);
            if (jump < -(COUNTS_PER_TURN / 2))
                turns = turns + 1'b1;
            else if (jump > COUNTS_PER_TURN / 2)
                turns = turns - 1'b1;
            last_raw = raw;

            sum = longint'(turns) * COUNTS_PER_TURN + longint'(raw) + longint'(zero_offset);
            total_w = sum[TOTAL_W-1:0];
            total   = longint'(total_w);
            r.total = total_w;

            // round half up, then saturate
            prod = total * longint'({32'd0, rad_per_count});
            prod = (prod + (longint'(1) <<< (ANGLE_SHIFT - 1))) >>> ANGLE_SHIFT;
            r.angle = ANGLE_W'(clamp_signed(prod, ANGLE_W));

            speed = longint'(rpm);
            prod  = speed * longint'({32'd0, rad_s_per_rpm});
            prod  = (prod + (longint'(1) <<< (OMEGA_SHIFT - 1))) >>> OMEGA_SHIFT;
            r.omega = OMEGA_W'(clamp_signed(prod, OMEGA_W));

            held_current = cur;
            held_temp    = temp;
            fresh_frame  = 1'b1;
        end else begin
            link_up     = fresh_frame;
            fresh_frame = 1'b0;
        end
        r.current = held_current;
        r.temp    = held_temp;
        r.online  = link_up;
        return r;
    endfunction

    function automatic void apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                           input logic [SCALE_W-1:0] data);
        case (idx)
            CFG_MECH_OFFSET: zero_offset   = data[OFFSET_W-1:0];
            CFG_ANGLE_SCALE: rad_per_count = data;
            CFG_OMEGA_SCALE: rad_s_per_rpm = data;
            default: ;
        endcase
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        if (!idling) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [SPEED_W-1:0] random_rpm();
        case ($urandom_range(0, 19))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return '0;
            default: return SPEED_W'($urandom());
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= REPORT_LINES)
            $display("[%0t] result %0d %s: got %h expected %h",
                     $time, result_no, what, got, want);
    endtask

    // offer one request and hold it until accepted
    task automatic send_request(
        input logic                        op,
        input logic [RAW_W-1:0]            raw,
        input logic signed [SPEED_W-1:0]   rpm,
        input logic signed [CURRENT_W-1:0] cur,
        input logic [TEMP_W-1:0]           temp
    );
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_opcode          <= op;
        s_encoder_raw     <= raw;
        s_speed_rpm       <= rpm;
        s_current_raw     <= cur;
        s_temperature_raw <= temp;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_frame(input logic [RAW_W-1:0] raw,
                              input logic signed [SPEED_W-1:0] rpm,
                              input logic signed [CURRENT_W-1:0] cur,
                              input logic [TEMP_W-1:0] temp);
        send_request(OP_FRAME, raw, rpm, cur, temp);
    endtask

    // tick payload is don't-care, keep it noisy
    task automatic send_tick();
        send_request(OP_TICK, RAW_W'($urandom()), SPEED_W'($urandom()),
                     CURRENT_W'($urandom()), TEMP_W'($urandom()));
    endtask

    // stop offering, wait for every result, then let the pipe settle
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (due_readings.size() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY + 2) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [SCALE_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        apply_register(idx, data);
    endtask

    // all three registers plus a write to the unmapped index
    task automatic set_config(input logic signed [OFFSET_W-1:0] ofs,
                              input logic [SCALE_W-1:0] ascale,
                              input logic [SCALE_W-1:0] oscale);
        logic [SCALE_W-1:0] noise;
        noise = $urandom();
        write_register(CFG_MECH_OFFSET, {noise[SCALE_W-1:OFFSET_W], ofs});
        write_register(CFG_ANGLE_SCALE, ascale);
        write_register(CFG_UNUSED, $urandom());
        write_register(CFG_OMEGA_SCALE, oscale);
        cfg_we <= 1'b0;
    endtask

    // wrap thresholds, first-frame wrap, liveness, field extremes
    task automatic test_directed();
        idling = 1'b1;
        send_tick();
        send_frame(13'd5000, '0, '0, '0);
        send_frame(13'd0, '0, '0, '0);
        send_frame(13'd8191, 16'sh7FFF, 16'sh8000, 8'd255);
        send_frame(13'd0, 16'sh8000, 16'sh7FFF, 8'd0);
        send_tick();
        send_tick();
        send_frame(13'd4096, 16'sd1, -16'sd1, 8'd1);
        send_frame(13'd0, -16'sd1, 16'sd1, 8'd128);
        send_frame(13'd4097, 16'sd100, 16'sd200, 8'd25);
        send_frame(13'd0, -16'sd100, -16'sd200, 8'd50);
        send_frame(13'd8191, 16'sd3000, 16'sd5, 8'd60);
        send_frame(13'd8191, -16'sd3000, -16'sd5, 8'd61);
        send_tick();
        send_frame(13'd4094, 16'sd1, 16'sd2, 8'd3);
        send_tick();
        shaft_pos = 13'd4094;
        wait_drained();
    endtask

    // register extremes, speed saturation both ways
    task automatic test_register_extremes();
        set_config(OFFSET_MIN, '1, '1);
        send_frame(13'd0, 16'sh7FFF, 16'sd7, 8'd8);
        send_frame(13'd1, 16'sh8000, -16'sd7, 8'd9);
        send_tick();
        wait_drained();
        set_config(OFFSET_MAX, '0, '0);
        send_frame(13'd8191, 16'sh7FFF, 16'sd11, 8'd12);
        send_frame(13'd0, 16'sh8000, -16'sd11, 8'd13);
        shaft_pos = 13'd0;
        wait_drained();
    endtask

    // long result stall while requests keep coming
    task automatic test_result_backpressure();
        logic [RAW_W-1:0] raw;
        set_config(OFFSET_W'($urandom()), ANGLE_SCALE_RESET, OMEGA_SCALE_RESET);
        idling = 1'b0;
        hold_off_cycles = HOLD_OFF_LEN;
        for (int n = 0; n < 24; n++) begin
            raw = shaft_pos + RAW_W'($urandom_range(0, 400) - 200);
            shaft_pos = raw;
            send_frame(raw, random_rpm(), CURRENT_W'($urandom()), TEMP_W'($urandom()));
        end
        wait_drained();
    endtask

    // random shaft motion with ticks, boundary jumps and noise
    task automatic test_random();
        logic [RAW_W-1:0] raw;
        int               pick;
        int               step;
        for (int phase = 0; phase < 5; phase++) begin
            wait_drained();
            case (phase)
                0:       set_config(OFFSET_W'($urandom()), $urandom(), $urandom());
                1:       set_config(OFFSET_MIN, '1, '1);
                2:       set_config(OFFSET_MAX, '0, '0);
                3:       set_config(OFFSET_W'($urandom()), ANGLE_SCALE_RESET,
                                    OMEGA_SCALE_RESET);
                default: set_config(OFFSET_W'($urandom()), $urandom(), $urandom());
            endcase
            idling = (phase != 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 12) begin
                    send_tick();
                end else begin
                    if (pick < 80) begin
                        case ($urandom_range(0, 2))
                            0:       step = $urandom_range(0, 128) - 64;
                            1:       step = $urandom_range(0, 2048) - 1024;
                            default: step = $urandom_range(0, 8190) - 4095;
                        endcase
                        raw = shaft_pos + RAW_W'(step);
                    end else if (pick < 90) begin
                        // jumps right around half a turn
                        step = $urandom_range(4095, 4097);
                        if ($urandom_range(0, 1)) step = -step;
                        raw = shaft_pos + RAW_W'(step);
                    end else begin
                        raw = RAW_W'($urandom());
                    end
                    shaft_pos = raw;
                    send_frame(raw, random_rpm(), CURRENT_W'($urandom()),
                               TEMP_W'($urandom()));
                end
            end
        end
        wait_drained();
    endtask

    // spin forward just under half a turn per frame, rounds step every other frame
    task automatic test_fast_spin();
        logic [RAW_W-1:0] raw;
        idling = 1'b0;
        set_config(OFFSET_MAX, '1, $urandom());
        raw = shaft_pos;
        for (int n = 0; n < SPIN_FRAMES; n++) begin
            raw = raw + 13'd4095;
            if (n % 25 == 0) send_tick();
            send_frame(raw, random_rpm(), CURRENT_W'($urandom()), TEMP_W'($urandom()));
        end
        shaft_pos = raw;
        wait_drained();
    endtask

    // result sink: random stalls plus the requested hold-off
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_cycles > 0) begin
                m_ready <= 1'b0;
                hold_off_cycles--;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // predict on accepted requests, check accepted results
    always @(posedge aclk) begin : track_results
        reading_t want;
        if (aresetn && s_valid && s_ready)
            due_readings.push_back(unwrap_and_scale(s_opcode, s_encoder_raw, s_speed_rpm,
                                                    s_current_raw, s_temperature_raw));
        if (aresetn && m_valid && m_ready) begin
            result_no++;
            if (due_readings.size() == 0) begin
                report_mismatch("unexpected result", 64'(m_item_kind), '0);
            end else begin
                want = due_readings.pop_front();
                if (m_item_kind !== want.kind)
                    report_mismatch("item_kind", 64'(m_item_kind), 64'(want.kind));
                if (m_total_count !== want.total)
                    report_mismatch("total_count", 64'(m_total_count), 64'(want.total));
                if (m_angle_rad !== want.angle)
                    report_mismatch("angle_rad", 64'(m_angle_rad), 64'(want.angle));
                if (m_omega_rad !== want.omega)
                    report_mismatch("omega_rad", 64'(m_omega_rad), 64'(want.omega));
                if (m_current_out !== want.current)
                    report_mismatch("current_out", 64'(m_current_out), 64'(want.current));
                if (m_temperature_out !== want.temp)
                    report_mismatch("temperature_out", 64'(m_temperature_out),
                                    64'(want.temp));
                if (m_online !== want.online)
                    report_mismatch("online", 64'(m_online), 64'(want.online));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_register_extremes();
        test_result_backpressure();
        test_random();
        test_fast_spin();
        wait_drained();
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* motor_feedback_turn_tracker.f */
hw/rtl/mftt_pkg.sv
hw/rtl/mftt_unwrap.sv
hw/rtl/mftt_scale.sv
hw/rtl/motor_feedback_turn_tracker.sv
sim/motor_feedback_turn_tracker_tb.sv
